// ----- src/compressed_instruction_expander_core_defines.svh -----
// Assertion macros for the compressed instruction expander.
// Used by the top level; no other dependencies.
`ifndef COMPRESSED_INSTRUCTION_EXPANDER_CORE_DEFINES_SVH
`define COMPRESSED_INSTRUCTION_EXPANDER_CORE_DEFINES_SVH
`ifndef SYNTH
`define CIE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CIE_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CIE_ASSERT(label, clk, rst, prop, msg)
`define CIE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- src/cie_pkg.sv -----
// Package for the compressed instruction expander: opcodes, classes, setting indices, config and result types.
// No dependencies.
`default_nettype none
package cie_pkg;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_FLOAD  = 7'h07;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OPIMMW = 7'h1B;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_FSTORE = 7'h27;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_OPW    = 7'h3B;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [2:0] CLS_C = 3'd0, CLS_ILL = 3'd1, CLS_D = 3'd2, CLS_F = 3'd3;
   localparam logic [2:0] CLS_M = 3'd4, CLS_ZBB = 3'd5, CLS_ZBA = 3'd6, CLS_ZICSR = 3'd7;

   localparam logic [1:0] CSR_XLEN = 2'd0, CSR_FLT = 2'd1, CSR_DBL = 2'd2;

   typedef struct packed {
      logic xlen_is_64;
      logic has_single_float;
      logic has_double_float;
   } cfg_type;

   typedef struct packed {
      logic        is_word_op;
      logic        is_double;
      logic [2:0]  ext_class;
      logic [17:0] immediate;
      logic [4:0]  src_reg_b;
      logic [4:0]  src_reg_a;
      logic [4:0]  dest_reg;
      logic [6:0]  upper_func;
      logic [2:0]  minor_func;
      logic [6:0]  major_opcode;
   } xinst_type;
endpackage
`default_nettype wire

// ----- src/cie_decode.sv -----
// Combinational expansion of one 16-bit compressed instruction.
// Depends on cie_pkg.
`default_nettype none
module cie_decode import cie_pkg::*; (
   input  wire logic [15:0] half_word,
   input  wire cfg_type     cfg,
   output xinst_type        res
);
   logic [15:0] w;
   logic [2:0]  f3;
   logic [1:0]  f2;
   logic [4:0]  rpa, rpb, r1, r2;
   logic [17:0] imm_lw, imm_ld, imm_ci, imm_cj, imm_ldsp, imm_lwsp, imm_sdsp, imm_swsp;
   logic [17:0] imm_b, imm_sp16, imm_lui;
   logic        ill;
   logic [2:0]  alu_f3;
   assign w = half_word;
   assign f3 = w[15:13];
   assign f2 = w[6:5];
   assign rpa = {2'b01, w[9:7]};
   assign rpb = {2'b01, w[4:2]};
   assign r1 = w[11:7];
   assign r2 = w[6:2];
   assign imm_lw = {11'd0, w[5], w[12:10], w[6], 2'b00};
   assign imm_ld = {10'd0, w[6:5], w[12:10], 3'b000};
   assign imm_ci = {{12{w[12]}}, w[12], w[6:2]};
   assign imm_cj = {{7{w[12]}}, w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
   assign imm_ldsp = {9'd0, w[4:2], w[12], w[6:5], 3'b000};
   assign imm_lwsp = {10'd0, w[3:2], w[12], w[6:4], 2'b00};
   assign imm_sdsp = {9'd0, w[9:7], w[12:10], 3'b000};
   assign imm_swsp = {10'd0, w[8:7], w[12:9], 2'b00};
   assign imm_b = {{10{w[12]}}, w[6:5], w[2], w[11:10], w[4:3], 1'b0};
   assign imm_sp16 = {{9{w[12]}}, w[4:3], w[5], w[2], w[6], 4'b0000};
   assign imm_lui = {w[12], w[6:2], 12'd0};

   always_comb begin
      unique case (f2)
         2'd0: alu_f3 = 3'd0;
         2'd1: alu_f3 = 3'd4;
         2'd2: alu_f3 = 3'd6;
         default: alu_f3 = 3'd7;
      endcase
   end

   always_comb begin
      res = '0;
      ill = 1'b0;
      if (w == 16'd0) begin
         ill = 1'b1;
      end else begin
         unique case (w[1:0])
            2'd0: begin
               unique case (f3)
                  3'd0: begin
                     res.major_opcode = OPC_OPIMM; res.dest_reg = rpb; res.src_reg_a = 5'd2;
                     res.immediate = {8'd0, w[10:7], w[12:11], w[5], w[6], 2'b00};
                  end
                  3'd1, 3'd5: begin
                     if (!cfg.has_double_float) ill = 1'b1;
                     res.major_opcode = f3[2] ? OPC_FSTORE : OPC_FLOAD;
                     res.minor_func = 3'd3; res.ext_class = CLS_D; res.is_double = 1'b1;
                     res.src_reg_a = rpa; res.immediate = imm_ld;
                     if (f3[2]) res.src_reg_b = rpb; else res.dest_reg = rpb;
                  end
                  3'd2, 3'd6: begin
                     res.major_opcode = f3[2] ? OPC_STORE : OPC_LOAD;
                     res.minor_func = 3'd2; res.src_reg_a = rpa; res.immediate = imm_lw;
                     if (f3[2]) res.src_reg_b = rpb; else res.dest_reg = rpb;
                  end
                  3'd3, 3'd7: begin
                     if (cfg.xlen_is_64) begin
                        res.major_opcode = f3[2] ? OPC_STORE : OPC_LOAD;
                        res.minor_func = 3'd3; res.immediate = imm_ld;
                     end else begin
                        if (!cfg.has_single_float) ill = 1'b1;
                        res.major_opcode = f3[2] ? OPC_FSTORE : OPC_FLOAD;
                        res.minor_func = 3'd2; res.ext_class = CLS_F; res.immediate = imm_lw;
                     end
                     res.src_reg_a = rpa;
                     if (f3[2]) res.src_reg_b = rpb; else res.dest_reg = rpb;
                  end
                  default: begin
                     if (w[12]) ill = 1'b1;
                     res.src_reg_a = rpa;
                     unique case (w[11:10])
                        2'd0: begin
                           res.major_opcode = OPC_LOAD; res.minor_func = 3'd4;
                           res.dest_reg = rpb; res.immediate = {16'd0, w[5], w[6]};
                        end
                        2'd1: begin
                           res.major_opcode = OPC_LOAD; res.minor_func = w[6] ? 3'd1 : 3'd5;
                           res.dest_reg = rpb; res.immediate = {16'd0, w[5], 1'b0};
                        end
                        2'd2: begin
                           res.major_opcode = OPC_STORE; res.minor_func = 3'd0;
                           res.src_reg_b = rpb; res.immediate = {16'd0, w[5], w[6]};
                        end
                        default: begin
                           if (w[6]) ill = 1'b1;
                           res.major_opcode = OPC_STORE; res.minor_func = 3'd1;
                           res.src_reg_b = rpb; res.immediate = {16'd0, w[5], 1'b0};
                        end
                     endcase
                  end
               endcase
            end
            2'd1: begin
               unique case (f3)
                  3'd0: begin
                     res.major_opcode = OPC_OPIMM; res.dest_reg = r1; res.src_reg_a = r1;
                     res.immediate = imm_ci;
                  end
                  3'd1: begin
                     if (cfg.xlen_is_64) begin
                        res.major_opcode = OPC_OPIMMW; res.is_word_op = 1'b1;
                        res.dest_reg = r1; res.src_reg_a = r1; res.immediate = imm_ci;
                     end else begin
                        res.major_opcode = OPC_JAL; res.dest_reg = 5'd1; res.immediate = imm_cj;
                     end
                  end
                  3'd2: begin
                     res.major_opcode = OPC_OPIMM; res.dest_reg = r1; res.immediate = imm_ci;
                  end
                  3'd3: begin
                     if (r1 == 5'd2) begin
                        res.major_opcode = OPC_OPIMM; res.dest_reg = 5'd2;
                        res.src_reg_a = 5'd2; res.immediate = imm_sp16;
                     end else begin
                        res.major_opcode = OPC_LUI; res.dest_reg = r1; res.immediate = imm_lui;
                     end
                  end
                  3'd4: begin
                     res.dest_reg = rpa; res.src_reg_a = rpa;
                     unique case (w[11:10])
                        2'd0, 2'd1: begin
                           res.major_opcode = OPC_OPIMM; res.minor_func = 3'd5;
                           res.upper_func = w[10] ? 7'h20 : 7'h00;
                           res.immediate = {12'd0, w[12], w[6:2]};
                        end
                        2'd2: begin
                           res.major_opcode = OPC_OPIMM; res.minor_func = 3'd7;
                           res.immediate = imm_ci;
                        end
                        default: begin
                           if (!w[12]) begin
                              res.major_opcode = OPC_OP; res.minor_func = alu_f3;
                              res.upper_func = (f2 == 2'd0) ? 7'h20 : 7'h00;
                              res.src_reg_b = rpb;
                           end else if (!f2[1]) begin
                              if (!cfg.xlen_is_64) ill = 1'b1;
                              res.major_opcode = OPC_OPW; res.is_word_op = 1'b1;
                              res.upper_func = (f2 == 2'd0) ? 7'h20 : 7'h00;
                              res.src_reg_b = rpb;
                           end else if (f2 == 2'd2) begin
                              res.major_opcode = OPC_OP; res.upper_func = 7'h01;
                              res.ext_class = CLS_M; res.src_reg_b = rpb;
                           end else begin
                              unique case (w[4:2])
                                 3'd0: begin
                                    res.major_opcode = OPC_OPIMM; res.minor_func = 3'd7;
                                    res.immediate = 18'd255;
                                 end
                                 3'd1, 3'd3: begin
                                    res.major_opcode = OPC_OPIMM; res.minor_func = 3'd1;
                                    res.upper_func = 7'h30; res.ext_class = CLS_ZBB;
                                    res.src_reg_b = w[3] ? 5'd5 : 5'd4;
                                    res.immediate = w[3] ? 18'd5 : 18'd4;
                                 end
                                 3'd2: begin
                                    res.major_opcode = cfg.xlen_is_64 ? OPC_OPW : OPC_OP;
                                    res.minor_func = 3'd4; res.upper_func = 7'h04;
                                    res.ext_class = CLS_ZBB; res.is_word_op = cfg.xlen_is_64;
                                 end
                                 3'd4: begin
                                    if (!cfg.xlen_is_64) ill = 1'b1;
                                    res.major_opcode = OPC_OPW; res.upper_func = 7'h04;
                                    res.ext_class = CLS_ZBA; res.is_word_op = 1'b1;
                                 end
                                 3'd5: begin
                                    res.major_opcode = OPC_OPIMM; res.minor_func = 3'd4;
                                    res.immediate = '1;
                                 end
                                 default: ill = 1'b1;
                              endcase
                           end
                        end
                     endcase
                  end
                  3'd5: begin
                     res.major_opcode = OPC_JAL; res.immediate = imm_cj;
                  end
                  default: begin
                     res.major_opcode = OPC_BRANCH; res.minor_func = {2'b00, f3[0]};
                     res.src_reg_a = rpa; res.immediate = imm_b;
                  end
               endcase
            end
            2'd2: begin
               unique case (f3)
                  3'd0: begin
                     res.major_opcode = OPC_OPIMM; res.minor_func = 3'd1;
                     res.dest_reg = r1; res.src_reg_a = r1;
                     res.immediate = {12'd0, w[12], r2};
                  end
                  3'd1, 3'd5: begin
                     if (!cfg.has_double_float) ill = 1'b1;
                     res.ext_class = CLS_D; res.is_double = 1'b1; res.src_reg_a = 5'd2;
                     res.minor_func = 3'd3;
                     if (f3[2]) begin
                        res.major_opcode = OPC_FSTORE; res.src_reg_b = r2;
                        res.immediate = imm_sdsp;
                     end else begin
                        res.major_opcode = OPC_FLOAD; res.dest_reg = r1;
                        res.immediate = imm_ldsp;
                     end
                  end
                  3'd2: begin
                     res.major_opcode = OPC_LOAD; res.minor_func = 3'd2; res.dest_reg = r1;
                     res.src_reg_a = 5'd2; res.immediate = imm_lwsp;
                  end
                  3'd6: begin
                     res.major_opcode = OPC_STORE; res.minor_func = 3'd2; res.src_reg_a = 5'd2;
                     res.src_reg_b = r2; res.immediate = imm_swsp;
                  end
                  3'd3, 3'd7: begin
                     res.src_reg_a = 5'd2;
                     if (cfg.xlen_is_64) begin
                        res.minor_func = 3'd3;
                        if (f3[2]) begin
                           res.major_opcode = OPC_STORE; res.src_reg_b = r2;
                           res.immediate = imm_sdsp;
                        end else begin
                           res.major_opcode = OPC_LOAD; res.dest_reg = r1;
                           res.immediate = imm_ldsp;
                        end
                     end else begin
                        if (!cfg.has_single_float) ill = 1'b1;
                        res.ext_class = CLS_F; res.minor_func = 3'd2;
                        if (f3[2]) begin
                           res.major_opcode = OPC_FSTORE; res.src_reg_b = r2;
                           res.immediate = imm_swsp;
                        end else begin
                           res.major_opcode = OPC_FLOAD; res.dest_reg = r1;
                           res.immediate = imm_lwsp;
                        end
                     end
                  end
                  default: begin
                     priority if (!w[12] && r2 == 5'd0) begin
                        res.major_opcode = OPC_JALR; res.src_reg_a = r1;
                     end else if (!w[12]) begin
                        res.major_opcode = OPC_OP; res.dest_reg = r1; res.src_reg_b = r2;
                     end else if (r1 == 5'd0 && r2 == 5'd0) begin
                        res.major_opcode = OPC_SYSTEM; res.ext_class = CLS_ZICSR;
                        res.immediate = 18'd1;
                     end else if (r2 == 5'd0) begin
                        res.major_opcode = OPC_JALR; res.dest_reg = 5'd1; res.src_reg_a = r1;
                     end else begin
                        res.major_opcode = OPC_OP; res.dest_reg = r1; res.src_reg_a = r1;
                        res.src_reg_b = r2;
                     end
                  end
               endcase
            end
            default: res = '0;
         endcase
      end
      if (ill) begin
         res = '0;
         res.ext_class = CLS_ILL;
      end
   end
endmodule
`default_nettype wire

// ----- src/compressed_instruction_expander_core.sv -----
// Top level of the compressed instruction expander: stream ports, settings, output register.
// Depends on cie_pkg, cie_decode and the assertion macro header.
`default_nettype none
`include "compressed_instruction_expander_core_defines.svh"
// Expands one 16-bit compressed RISC-V instruction per request into the fields of
// the equivalent 32-bit instruction. A request is registered on entry, expanded by
// one combinational decoder and held in a result register; one request is taken
// every cycle while the result side keeps up. Three setting bits (RV64, F, D) are
// written on the csr_ channel; the user must write them only while the block is
// idle, as the block itself does not enforce this.
module compressed_instruction_expander_core import cie_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // half_word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // major_opcode, minor_func, upper_func, dest_reg,
                                         // src_reg_a, src_reg_b, immediate, ext_class,
                                         // is_double, is_word_op, zero fill
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [0:0]  csr_data
);
   cfg_type     cfg_ff, cfg_in;
   logic        in_vld_ff, in_vld_in;
   logic [15:0] in_data_ff, in_data_in;
   logic        out_vld_ff, out_vld_in;
   xinst_type   out_data_ff, out_data_in, dec;
   logic        adv;

   cie_decode u_decode (.half_word(in_data_ff), .cfg(cfg_ff), .res(dec));

   assign adv = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || adv;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {9'd0, out_data_ff};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_XLEN: cfg_in.xlen_is_64 = csr_data[0];
            CSR_FLT:  cfg_in.has_single_float = csr_data[0];
            CSR_DBL:  cfg_in.has_double_float = csr_data[0];
            default:  cfg_in = cfg_ff;
         endcase
      end
      in_vld_in = in_vld_ff;
      in_data_in = in_data_ff;
      out_vld_in = out_vld_ff;
      out_data_in = out_data_ff;
      if (adv) begin
         out_vld_in = in_vld_ff;
         out_data_in = dec;
      end
      if (req_tready) begin
         in_vld_in = req_tvalid;
         in_data_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{xlen_is_64: 1'b0, has_single_float: 1'b1, has_double_float: 1'b1};
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_data_ff <= in_data_in;
      out_data_ff <= out_data_in;
   end

   `CIE_ASSERT(a_hold, clock, reset, out_vld_ff && !rsp_tready |=> out_vld_ff, "result lost")
   `CIE_ASSERT(a_stall, clock, reset, in_vld_ff && !adv |-> !req_tready, "request overrun")
   `CIE_ASSERT(a_ill, clock, reset, out_vld_ff && out_data_ff.ext_class == CLS_ILL |-> out_data_ff.major_opcode == 7'd0, "illegal result not cleared")
endmodule
`default_nettype wire

// ----- verif/tb_compressed_instruction_expander_core.sv -----
// Self-checking testbench for the compressed instruction expander core.
// Predicts the expansion of every accepted request and checks each response field by field.
// Depends on cie_pkg and the compressed_instruction_expander_core RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_compressed_instruction_expander_core;
   import cie_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [0:0]  csr_data = '0;

   compressed_instruction_expander_core dut (.*);

   always #6 clock = ~clock;

   cfg_type     settings;
   logic [15:0] pending_words[$];
   xinst_type   expected_expansions[$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          hold_off = 0;
   bit          driving = 1'b0;
   logic        req_tready_seen = 1'b0;

   function automatic logic [17:0] sx(logic [17:0] v, int n);
      logic [17:0] m;
      m = 18'd1 << (n - 1);
      v = v & ((m << 1) - 18'd1);
      return (v ^ m) - m;
   endfunction

   function automatic xinst_type illegal_expansion();
      xinst_type x;
      x = '0;
      x.ext_class = CLS_ILL;
      return x;
   endfunction

   function automatic xinst_type expand_half_word(logic [15:0] w, cfg_type c);
      xinst_type   x;
      logic [2:0]  f3;
      logic [1:0]  f2;
      logic [4:0]  r1, r2, rp7, rp2;
      logic [17:0] imm_lw, imm_ld, imm_ci, imm_cj, imm_ldsp, imm_lwsp, imm_sdsp, imm_swsp;
      x = '0;
      f3 = w[15:13];
      f2 = w[6:5];
      r1 = w[11:7];
      r2 = w[6:2];
      rp7 = {2'b01, w[9:7]};
      rp2 = {2'b01, w[4:2]};
      imm_lw = {11'd0, w[5], w[12:10], w[6], 2'b00};
      imm_ld = {10'd0, w[6:5], w[12:10], 3'b000};
      imm_ci = sx({12'd0, w[12], w[6:2]}, 6);
      imm_cj = sx({6'd0, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0}, 12);
      imm_ldsp = {9'd0, w[4:2], w[12], w[6:5], 3'b000};
      imm_lwsp = {10'd0, w[3:2], w[12], w[6:4], 2'b00};
      imm_sdsp = {9'd0, w[9:7], w[12:10], 3'b000};
      imm_swsp = {10'd0, w[8:7], w[12:9], 2'b00};
      if (w == 16'd0) return illegal_expansion();
      case (w[1:0])
         2'd0: begin
            case (f3)
               3'd0: begin
                  x.major_opcode = OPC_OPIMM; x.dest_reg = rp2; x.src_reg_a = 5'd2;
                  x.immediate = {8'd0, w[10:7], w[12:11], w[5], w[6], 2'b00};
               end
               3'd1, 3'd5: begin
                  if (!c.has_double_float) return illegal_expansion();
                  x.major_opcode = (f3 == 3'd1) ? OPC_FLOAD : OPC_FSTORE;
                  x.minor_func = 3'd3; x.ext_class = CLS_D; x.is_double = 1'b1;
                  x.src_reg_a = rp7; x.immediate = imm_ld;
                  if (f3 == 3'd1) x.dest_reg = rp2; else x.src_reg_b = rp2;
               end
               3'd2, 3'd6: begin
                  x.major_opcode = (f3 == 3'd2) ? OPC_LOAD : OPC_STORE;
                  x.minor_func = 3'd2; x.src_reg_a = rp7; x.immediate = imm_lw;
                  if (f3 == 3'd2) x.dest_reg = rp2; else x.src_reg_b = rp2;
               end
               3'd3, 3'd7: begin
                  if (c.xlen_is_64) begin
                     x.major_opcode = (f3 == 3'd3) ? OPC_LOAD : OPC_STORE;
                     x.minor_func = 3'd3; x.immediate = imm_ld;
                  end else if (c.has_single_float) begin
                     x.major_opcode = (f3 == 3'd3) ? OPC_FLOAD : OPC_FSTORE;
                     x.minor_func = 3'd2; x.ext_class = CLS_F; x.immediate = imm_lw;
                  end else return illegal_expansion();
                  x.src_reg_a = rp7;
                  if (f3 == 3'd3) x.dest_reg = rp2; else x.src_reg_b = rp2;
               end
               default: begin
                  if (w[12]) return illegal_expansion();
                  x.src_reg_a = rp7;
                  case (w[11:10])
                     2'd0: begin
                        x.major_opcode = OPC_LOAD; x.minor_func = 3'd4; x.dest_reg = rp2;
                        x.immediate = {16'd0, w[5], w[6]};
                     end
                     2'd1: begin
                        x.major_opcode = OPC_LOAD; x.minor_func = w[6] ? 3'd1 : 3'd5;
                        x.dest_reg = rp2; x.immediate = {16'd0, w[5], 1'b0};
                     end
                     2'd2: begin
                        x.major_opcode = OPC_STORE; x.src_reg_b = rp2;
                        x.immediate = {16'd0, w[5], w[6]};
                     end
                     default: begin
                        if (w[6]) return illegal_expansion();
                        x.major_opcode = OPC_STORE; x.minor_func = 3'd1; x.src_reg_b = rp2;
                        x.immediate = {16'd0, w[5], 1'b0};
                     end
                  endcase
               end
            endcase
         end
         2'd1: begin
            case (f3)
               3'd0: begin
                  x.major_opcode = OPC_OPIMM; x.dest_reg = r1; x.src_reg_a = r1;
                  x.immediate = imm_ci;
               end
               3'd1: begin
                  if (c.xlen_is_64) begin
                     x.major_opcode = OPC_OPIMMW; x.is_word_op = 1'b1;
                     x.dest_reg = r1; x.src_reg_a = r1; x.immediate = imm_ci;
                  end else begin
                     x.major_opcode = OPC_JAL; x.dest_reg = 5'd1; x.immediate = imm_cj;
                  end
               end
               3'd2: begin
                  x.major_opcode = OPC_OPIMM; x.dest_reg = r1; x.immediate = imm_ci;
               end
               3'd3: begin
                  if (r1 == 5'd2) begin
                     x.major_opcode = OPC_OPIMM; x.dest_reg = 5'd2; x.src_reg_a = 5'd2;
                     x.immediate = sx({8'd0, w[12], w[4:3], w[5], w[2], w[6], 4'd0}, 10);
                  end else begin
                     x.major_opcode = OPC_LUI; x.dest_reg = r1;
                     x.immediate = {w[12], w[6:2], 12'd0};
                  end
               end
               3'd4: begin
                  case (w[11:10])
                     2'd0, 2'd1: begin
                        x.major_opcode = OPC_OPIMM; x.minor_func = 3'd5;
                        x.upper_func = w[10] ? 7'h20 : 7'h00;
                        x.dest_reg = rp7; x.src_reg_a = rp7;
                        x.immediate = {12'd0, w[12], w[6:2]};
                     end
                     2'd2: begin
                        x.major_opcode = OPC_OPIMM; x.minor_func = 3'd7;
                        x.dest_reg = rp7; x.src_reg_a = rp7; x.immediate = imm_ci;
                     end
                     default: begin
                        x.dest_reg = rp7; x.src_reg_a = rp7; x.src_reg_b = rp2;
                        if (!w[12]) begin
                           x.major_opcode = OPC_OP;
                           case (f2)
                              2'd0: x.minor_func = 3'd0;
                              2'd1: x.minor_func = 3'd4;
                              2'd2: x.minor_func = 3'd6;
                              default: x.minor_func = 3'd7;
                           endcase
                           x.upper_func = (f2 == 2'd0) ? 7'h20 : 7'h00;
                        end else if (f2 < 2'd2) begin
                           if (!c.xlen_is_64) return illegal_expansion();
                           x.major_opcode = OPC_OPW; x.is_word_op = 1'b1;
                           x.upper_func = (f2 == 2'd0) ? 7'h20 : 7'h00;
                        end else if (f2 == 2'd2) begin
                           x.major_opcode = OPC_OP; x.upper_func = 7'h01; x.ext_class = CLS_M;
                        end else begin
                           x.src_reg_b = 5'd0;
                           case (w[4:2])
                              3'd0: begin
                                 x.major_opcode = OPC_OPIMM; x.minor_func = 3'd7;
                                 x.immediate = 18'd255;
                              end
                              3'd1, 3'd3: begin
                                 x.major_opcode = OPC_OPIMM; x.minor_func = 3'd1;
                                 x.upper_func = 7'h30; x.ext_class = CLS_ZBB;
                                 x.src_reg_b = (w[4:2] == 3'd1) ? 5'd4 : 5'd5;
                                 x.immediate = {13'd0, x.src_reg_b};
                              end
                              3'd2: begin
                                 x.major_opcode = c.xlen_is_64 ? OPC_OPW : OPC_OP;
                                 x.minor_func = 3'd4; x.upper_func = 7'h04;
                                 x.ext_class = CLS_ZBB; x.is_word_op = c.xlen_is_64;
                              end
                              3'd4: begin
                                 if (!c.xlen_is_64) return illegal_expansion();
                                 x.major_opcode = OPC_OPW; x.upper_func = 7'h04;
                                 x.ext_class = CLS_ZBA; x.is_word_op = 1'b1;
                              end
                              3'd5: begin
                                 x.major_opcode = OPC_OPIMM; x.minor_func = 3'd4;
                                 x.immediate = '1;
                              end
                              default: return illegal_expansion();
                           endcase
                        end
                     end
                  endcase
               end
               3'd5: begin
                  x.major_opcode = OPC_JAL; x.immediate = imm_cj;
               end
               default: begin
                  x.major_opcode = OPC_BRANCH; x.minor_func = (f3 == 3'd7) ? 3'd1 : 3'd0;
                  x.src_reg_a = rp7;
                  x.immediate = sx({9'd0, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0}, 9);
               end
            endcase
         end
         2'd2: begin
            case (f3)
               3'd0: begin
                  x.major_opcode = OPC_OPIMM; x.minor_func = 3'd1;
                  x.dest_reg = r1; x.src_reg_a = r1; x.immediate = {12'd0, w[12], r2};
               end
               3'd1, 3'd5: begin
                  if (!c.has_double_float) return illegal_expansion();
                  x.ext_class = CLS_D; x.is_double = 1'b1; x.src_reg_a = 5'd2;
                  x.minor_func = 3'd3;
                  if (f3 == 3'd1) begin
                     x.major_opcode = OPC_FLOAD; x.dest_reg = r1; x.immediate = imm_ldsp;
                  end else begin
                     x.major_opcode = OPC_FSTORE; x.src_reg_b = r2; x.immediate = imm_sdsp;
                  end
               end
               3'd2: begin
                  x.major_opcode = OPC_LOAD; x.minor_func = 3'd2; x.dest_reg = r1;
                  x.src_reg_a = 5'd2; x.immediate = imm_lwsp;
               end
               3'd6: begin
                  x.major_opcode = OPC_STORE; x.minor_func = 3'd2; x.src_reg_a = 5'd2;
                  x.src_reg_b = r2; x.immediate = imm_swsp;
               end
               3'd3, 3'd7: begin
                  if (c.xlen_is_64) begin
                     x.minor_func = 3'd3;
                     if (f3 == 3'd3) begin
                        x.major_opcode = OPC_LOAD; x.dest_reg = r1; x.immediate = imm_ldsp;
                     end else begin
                        x.major_opcode = OPC_STORE; x.src_reg_b = r2; x.immediate = imm_sdsp;
                     end
                  end else if (c.has_single_float) begin
                     x.ext_class = CLS_F; x.minor_func = 3'd2;
                     if (f3 == 3'd3) begin
                        x.major_opcode = OPC_FLOAD; x.dest_reg = r1; x.immediate = imm_lwsp;
                     end else begin
                        x.major_opcode = OPC_FSTORE; x.src_reg_b = r2;
                        x.immediate = imm_swsp;
                     end
                  end else return illegal_expansion();
                  x.src_reg_a = 5'd2;
               end
               default: begin
                  if (!w[12] && r2 == 5'd0) begin
                     x.major_opcode = OPC_JALR; x.src_reg_a = r1;
                  end else if (!w[12]) begin
                     x.major_opcode = OPC_OP; x.dest_reg = r1; x.src_reg_b = r2;
                  end else if (r1 == 5'd0 && r2 == 5'd0) begin
                     x.major_opcode = OPC_SYSTEM; x.ext_class = CLS_ZICSR; x.immediate = 18'd1;
                  end else if (r2 == 5'd0) begin
                     x.major_opcode = OPC_JALR; x.dest_reg = 5'd1; x.src_reg_a = r1;
                  end else begin
                     x.major_opcode = OPC_OP; x.dest_reg = r1; x.src_reg_a = r1;
                     x.src_reg_b = r2;
                  end
               end
            endcase
         end
         default: ;
      endcase
      return x;
   endfunction

   // Driver: bursts with random gaps, valid changed only when no request waits; random rsp_tready.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_tvalid && !req_tready_seen)) begin
            if (pending_words.size() > 0 && driving) begin
               if (gap_left > 0) begin
                  gap_left <= gap_left - 1;
                  req_tvalid <= 1'b0;
               end else begin
                  req_tdata <= pending_words.pop_front();
                  req_tvalid <= 1'b1;
                  if (burst_left == 0) begin
                     burst_left <= $urandom_range(1, 30);
                     gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                  end else begin
                     burst_left <= burst_left - 1;
                  end
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 9) < 7) || (expected_expansions.size() % 16 < 3);
         end
      end
   end

   // Monitor: records accepted requests, checks responses at the rising edge and runs the idle watchdog.
   always @(posedge clock) begin
      xinst_type actual, wanted;
      req_tready_seen <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_expansions.push_back(expand_half_word(req_tdata, settings));
         end
         if (rsp_tvalid && rsp_tready) begin
            actual = rsp_tdata[$bits(xinst_type)-1:0];
            if (expected_expansions.size() == 0) begin
               $error("response with no request outstanding: %h", actual);
               fail_count++;
            end else begin
               wanted = expected_expansions.pop_front();
               if (actual.major_opcode !== wanted.major_opcode) begin
                  $error("major_opcode: expected %h, got %h", wanted.major_opcode,
                         actual.major_opcode); fail_count++; end
               if (actual.minor_func !== wanted.minor_func) begin
                  $error("minor_func: expected %h, got %h", wanted.minor_func,
                         actual.minor_func); fail_count++; end
               if (actual.upper_func !== wanted.upper_func) begin
                  $error("upper_func: expected %h, got %h", wanted.upper_func,
                         actual.upper_func); fail_count++; end
               if (actual.dest_reg !== wanted.dest_reg) begin
                  $error("dest_reg: expected %0d, got %0d", wanted.dest_reg,
                         actual.dest_reg); fail_count++; end
               if (actual.src_reg_a !== wanted.src_reg_a) begin
                  $error("src_reg_a: expected %0d, got %0d", wanted.src_reg_a,
                         actual.src_reg_a); fail_count++; end
               if (actual.src_reg_b !== wanted.src_reg_b) begin
                  $error("src_reg_b: expected %0d, got %0d", wanted.src_reg_b,
                         actual.src_reg_b); fail_count++; end
               if (actual.immediate !== wanted.immediate) begin
                  $error("immediate: expected %h, got %h", wanted.immediate,
                         actual.immediate); fail_count++; end
               if (actual.ext_class !== wanted.ext_class) begin
                  $error("ext_class: expected %0d, got %0d", wanted.ext_class,
                         actual.ext_class); fail_count++; end
               if (actual.is_double !== wanted.is_double) begin
                  $error("is_double: expected %b, got %b", wanted.is_double,
                         actual.is_double); fail_count++; end
               if (actual.is_word_op !== wanted.is_word_op) begin
                  $error("is_word_op: expected %b, got %b", wanted.is_word_op,
                         actual.is_word_op); fail_count++; end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) || (hold_off > 0))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic write_setting(logic [1:0] index, logic value);
      @(negedge clock);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_XLEN: settings.xlen_is_64 = value;
         CSR_FLT:  settings.has_single_float = value;
         default:  settings.has_double_float = value;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(cfg_type c);
      write_setting(CSR_XLEN, c.xlen_is_64);
      write_setting(CSR_FLT, c.has_single_float);
      write_setting(CSR_DBL, c.has_double_float);
   endtask

   task automatic drain();
      driving = 1'b1;
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req_tvalid || expected_expansions.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
      driving = 1'b0;
   endtask

   function automatic logic [15:0] random_word();
      logic [15:0] w;
      w = 16'($urandom);
      case ($urandom_range(0, 5))
         0: w[1:0] = 2'd0;
         1, 2: w[1:0] = 2'd1;
         3, 4: w[1:0] = 2'd2;
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) w[15:10] = {3'b100, $urandom_range(0, 1) ? 3'b111 : 3'b011};
      if ($urandom_range(0, 7) == 0) w[6:2] = 5'd0;
      if ($urandom_range(0, 7) == 0) w[11:7] = ($urandom_range(0, 1)) ? 5'd0 : 5'd2;
      return w;
   endfunction

   initial begin
      cfg_type phases[6];
      phases[0] = 3'b011; phases[1] = 3'b111; phases[2] = 3'b000;
      phases[3] = 3'b100; phases[4] = 3'b010; phases[5] = 3'b001;
      settings = 3'b011;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (phases[p]) begin
         apply_settings(phases[p]);
         if (p == 0) begin
            pending_words.push_back(16'h0000);
            pending_words.push_back(16'hFFFF);
            pending_words.push_back(16'hFFFE);
            pending_words.push_back(16'hFFFD);
            pending_words.push_back(16'hFFFC);
            pending_words.push_back(16'h9002);
            pending_words.push_back(16'h8082);
            pending_words.push_back(16'h9082);
            pending_words.push_back(16'h0001);
            pending_words.push_back(16'h8000);
            pending_words.push_back(16'h9C61);
            pending_words.push_back(16'h9C65);
            pending_words.push_back(16'h9C75);
            pending_words.push_back(16'h9C79);
            pending_words.push_back(16'h9C7D);
            pending_words.push_back(16'h9C21);
            pending_words.push_back(16'h9C41);
            pending_words.push_back(16'h8040);
            pending_words.push_back(16'h9000);
            pending_words.push_back(16'h8C40);
            pending_words.push_back(16'h6101);
            pending_words.push_back(16'h7FFD);
         end
         for (int i = 0; i < 300; i++) pending_words.push_back(random_word());
         if (p == 1) hold_off = 200;
         drain();
      end
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
